[sv/arpc_pkg.sv]
// arpc_pkg: shared types and constants for the ARP cache engine.
// No dependencies; imported by arpc_cell and arp_cache_engine.
package arpc_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;

	localparam logic CMD_RESOLVE = 1'b0;
	localparam logic CMD_RECEIVE = 1'b1;

	localparam logic [15:0] HW_ETHERNET    = 16'h0001;
	localparam logic [15:0] PROTO_IPV4     = 16'h0800;
	localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
	localparam logic [15:0] OP_REQUEST     = 16'd1;
	localparam logic [15:0] OP_REPLY       = 16'd2;

	localparam logic [31:0] IP_BCAST  = 32'hFFFF_FFFF;
	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic        cmd;
		logic [31:0] lookup_ip;
		logic [15:0] hw_type;
		logic [15:0] prot_type;
		logic [7:0]  hw_len;
		logic [7:0]  prot_len;
		logic [15:0] opcode;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] tgt_ip;
	} in_t;

	typedef struct packed {
		logic        found;
		logic [47:0] resolved_mac;
		logic        table_updated;
		logic        send_reply;
		logic [47:0] reply_mac;
		logic [31:0] reply_ip;
	} out_t;

	// search token walking the cell row
	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic        hit;
		logic [47:0] mac;
		logic        free;
	} tok_t;

	// write broadcast to every cell
	typedef struct packed {
		logic        en;
		logic [31:0] ip;
		logic [47:0] mac;
	} wr_t;

endpackage

[sv/arpc_cell.sv]
// arpc_cell: one table slot plus one stage of the search token row.
// Depends on arpc_pkg.
module arpc_cell
	import arpc_pkg::*;
#(
	parameter int IDX_W    = 5,
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tok_t             tok_in,
	input  logic [IDX_W-1:0] hit_idx_in,
	input  logic [IDX_W-1:0] free_idx_in,
	output tok_t             tok_out,
	output logic [IDX_W-1:0] hit_idx_out,
	output logic [IDX_W-1:0] free_idx_out,
	input  wr_t              wr,
	input  logic [IDX_W-1:0] wr_idx
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic        valid_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;

	tok_t             tok_s1;
	logic [IDX_W-1:0] hit_idx_s1;
	logic [IDX_W-1:0] free_idx_s1;

	tok_t             tok_nxt;
	logic [IDX_W-1:0] hit_nxt;
	logic [IDX_W-1:0] free_nxt;
	logic             match;
	logic             wr_here;

	assign match   = valid_q && (ip_q == tok_in.ip);
	assign wr_here = wr.en && (wr_idx == MY_IDX);

	// first match and first free slot win; later cells leave them alone
	always_comb begin
		tok_nxt  = tok_in;
		hit_nxt  = hit_idx_in;
		free_nxt = free_idx_in;
		if (!tok_in.hit && match) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.mac = mac_q;
			hit_nxt     = MY_IDX;
		end
		if (!tok_in.free && !valid_q) begin
			tok_nxt.free = 1'b1;
			free_nxt     = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_s1  <= '0;
		end else begin
			tok_s1 <= tok_nxt;
			if (wr_here) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_s1  <= hit_nxt;
		free_idx_s1 <= free_nxt;
		if (wr_here) begin
			ip_q  <= wr.ip;
			mac_q <= wr.mac;
		end
	end

	assign tok_out      = tok_s1;
	assign hit_idx_out  = hit_idx_s1;
	assign free_idx_out = free_idx_s1;

endmodule

[sv/arp_cache_engine.sv]
// arp_cache_engine: top level, token injection, result and write-back control.
// Depends on arpc_pkg and arpc_cell.
//
// IPv4-to-MAC cache built as a row of TABLE_ENTRIES cells. An item is taken
// when start is high and busy is low; its search token then walks the row one
// cell per cycle, and the result strobe is registered from the token leaving
// the last cell and stays high for exactly one cycle. The receiver cannot
// stall: the result must be taken in that cycle. busy is low again in the
// strobe cycle, so no new item is taken before the last one is through. A
// table update for a received request or reply is written into the chosen
// cell at the same edge that loads the result. The user must write own_ip via
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
module arp_cache_engine
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_t         item,
	output logic        result_strobe,
	output out_t        result,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic        busy_q;
	logic        result_strobe_q;
	out_t        result_q;
	in_t         item_q;
	logic [31:0] own_ip_q;

	tok_t             tok      [0:TABLE_ENTRIES];
	logic [IDX_W-1:0] hit_idx  [0:TABLE_ENTRIES];
	logic [IDX_W-1:0] free_idx [0:TABLE_ENTRIES];

	wr_t              wr;
	logic [IDX_W-1:0] wr_idx;
	logic             accept;
	logic             done;
	logic             hdr_ok;
	logic             op_ok;
	out_t             res_nxt;

	assign accept = start && !busy_q;
	assign done   = tok[TABLE_ENTRIES].valid;
	assign busy   = busy_q;

	always_comb begin
		tok[0]       = '0;
		tok[0].valid = accept;
		tok[0].ip    = (item.cmd == CMD_RESOLVE) ? item.lookup_ip : item.sender_ip;
		hit_idx[0]   = '0;
		free_idx[0]  = '0;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		arpc_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.tok_in       (tok[i]),
			.hit_idx_in   (hit_idx[i]),
			.free_idx_in  (free_idx[i]),
			.tok_out      (tok[i+1]),
			.hit_idx_out  (hit_idx[i+1]),
			.free_idx_out (free_idx[i+1]),
			.wr           (wr),
			.wr_idx       (wr_idx)
		);
	end

	assign hdr_ok = (item_q.hw_type == HW_ETHERNET) && (item_q.prot_type == PROTO_IPV4) &&
		(item_q.hw_len == HW_LEN_ETH) && (item_q.prot_len == PROTO_LEN_IPV4);
	assign op_ok  = (item_q.opcode == OP_REQUEST) || (item_q.opcode == OP_REPLY);

	always_comb begin
		wr.en   = done && (item_q.cmd == CMD_RECEIVE) && hdr_ok && op_ok;
		wr.ip   = item_q.sender_ip;
		wr.mac  = item_q.sender_mac;
		// refresh existing entry, else lowest free slot, else slot 0
		if (tok[TABLE_ENTRIES].hit) begin
			wr_idx = hit_idx[TABLE_ENTRIES];
		end else if (tok[TABLE_ENTRIES].free) begin
			wr_idx = free_idx[TABLE_ENTRIES];
		end else begin
			wr_idx = '0;
		end
	end

	always_comb begin
		res_nxt = '0;
		if (item_q.cmd == CMD_RESOLVE) begin
			if (item_q.lookup_ip == IP_BCAST) begin
				res_nxt.found        = 1'b1;
				res_nxt.resolved_mac = MAC_BCAST;
			end else if (tok[TABLE_ENTRIES].hit) begin
				res_nxt.found        = 1'b1;
				res_nxt.resolved_mac = tok[TABLE_ENTRIES].mac;
			end
		end else if (hdr_ok && op_ok) begin
			res_nxt.table_updated = 1'b1;
			if ((item_q.opcode == OP_REQUEST) && (item_q.tgt_ip == own_ip_q)) begin
				res_nxt.send_reply = 1'b1;
				res_nxt.reply_mac  = item_q.sender_mac;
				res_nxt.reply_ip   = item_q.sender_ip;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q          <= 1'b0;
			result_strobe_q <= 1'b0;
			own_ip_q        <= '0;
		end else begin
			result_strobe_q <= done;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				own_ip_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (done) begin
			result_q <= res_nxt;
		end
	end

	assign result_strobe = result_strobe_q;
	assign result        = result_q;

`ifndef SYNTH
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !busy)
		else $error("result beat while busy");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("token left the row while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("two result beats in a row");
`endif

endmodule
